// ----- sv/flv_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// FLV tag stream parser package
// Shared constants for the FLV parser: phase codes, event codes, error codes,
// header geometry and the byte values that the header checks compare against.
// ----------------------------------------------------------------------------
package flv_pkg;

    // Parser phases.
    localparam logic [2:0] PH_FILE_HDR  = 3'd0;
    localparam logic [2:0] PH_PREV_SIZE = 3'd1;
    localparam logic [2:0] PH_TAG_HDR   = 3'd2;
    localparam logic [2:0] PH_PAYLOAD   = 3'd3;
    localparam logic [2:0] PH_ERROR     = 3'd4;

    // Result event codes.
    localparam logic [2:0] EV_CONSUMED  = 3'd0;
    localparam logic [2:0] EV_FILE_OK   = 3'd1;
    localparam logic [2:0] EV_PREV_DONE = 3'd2;
    localparam logic [2:0] EV_TAG_OK    = 3'd3;
    localparam logic [2:0] EV_PAYLOAD   = 3'd4;
    localparam logic [2:0] EV_ERROR     = 3'd5;

    // Error codes.
    localparam logic [2:0] ERR_NONE      = 3'd0;
    localparam logic [2:0] ERR_SIGNATURE = 3'd1;
    localparam logic [2:0] ERR_FLAG_RSV  = 3'd2;
    localparam logic [2:0] ERR_OFFSET    = 3'd3;
    localparam logic [2:0] ERR_TAG_RSV   = 3'd4;
    localparam logic [2:0] ERR_TYPE      = 3'd5;
    localparam logic [2:0] ERR_STREAM_ID = 3'd6;
    localparam logic [2:0] ERR_STUCK     = 3'd7;

    // Header geometry: last byte index of each header kind.
    localparam int HDR_DEPTH = 11;
    localparam logic [3:0] FILE_HDR_LAST  = 4'd8;
    localparam logic [3:0] PREV_SIZE_LAST = 4'd3;
    localparam logic [3:0] TAG_HDR_LAST   = 4'd10;

    // Byte constants.
    localparam logic [7:0] SIG_F = 8'h46;
    localparam logic [7:0] SIG_L = 8'h4c;
    localparam logic [7:0] SIG_V = 8'h56;
    localparam logic [7:0] FLAG_RSV_HI   = 8'hf8;
    localparam logic [7:0] FLAG_RSV_LO   = 8'h02;
    localparam logic [7:0] TAG_RSV_MASK  = 8'hc0;
    localparam logic [7:0] VERSION_ONE   = 8'h01;
    localparam logic [31:0] DATA_OFFSET  = 32'h0000_0009;
    localparam logic [4:0] TYPE_AUDIO    = 5'h08;
    localparam logic [4:0] TYPE_VIDEO    = 5'h09;
    localparam logic [4:0] TYPE_SCRIPT   = 5'h12;

endpackage

// ----- sv/flv_tag_stream_parser.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// FLV tag stream parser
// Checks an FLV byte stream one byte per transaction: the file header, then
// records of previous-tag size, tag header and payload bytes.
// ----------------------------------------------------------------------------
// The result of an accepted byte is registered and offered the next cycle.
// Throughput: one byte per cycle; the parse state and the output register
// update together in each accepting cycle, so nothing limits the rate below
// one byte per clock while the result side keeps taking transactions.
// Reset: aresetn is synchronous and active low; it returns the parser to the
// file header phase, clears all latched fields and the latched error, and
// empties the output register.
// ----------------------------------------------------------------------------
module flv_tag_stream_parser (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_in_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_event_res,
    output logic [2:0]  m_error_code,
    output logic [7:0]  m_version,
    output logic        m_has_audio,
    output logic        m_has_video,
    output logic [31:0] m_prior_tag_size,
    output logic        m_filter_flag,
    output logic [4:0]  m_tag_kind,
    output logic [23:0] m_payload_size,
    output logic [31:0] m_time_stamp,
    output logic [7:0]  m_payload_byte,
    output logic        m_payload_last
);

    // Parser state.
    logic [2:0]  phase_reg, phase_next;
    logic [3:0]  idx_reg, idx_next;
    logic [23:0] left_reg, left_next;
    logic [2:0]  err_reg, err_next;
    logic [7:0]  hdr_reg [0:flv_pkg::HDR_DEPTH-1];
    logic        hdr_we;

    // Latched header fields. They change only when a transaction is accepted
    // and already hold the values that belong to the result in the output
    // register, so they drive the result ports directly.
    logic [7:0]  version_reg, version_next;
    logic        audio_reg, audio_next;
    logic        video_reg, video_next;
    logic [31:0] prior_reg, prior_next;
    logic        filter_reg, filter_next;
    logic [4:0]  kind_reg, kind_next;
    logic [23:0] size_reg, size_next;
    logic [31:0] ts_reg, ts_next;

    // Output register for the per-byte part of the result.
    logic        valid_reg;
    logic [2:0]  event_reg, event_next;
    logic [2:0]  code_reg, code_next;
    logic [7:0]  pbyte_reg, pbyte_next;
    logic        plast_reg, plast_next;

    logic        accept;

    // Header checks. The byte being accepted is the last byte of the header,
    // so it is taken straight from the input rather than from storage.
    logic        sig_bad, flag_bad, off_bad;
    logic [31:0] data_offset;
    logic [4:0]  tag_type;
    logic        tag_rsv_bad, type_bad, sid_bad;
    logic [23:0] tag_size;

    // The output register can take a new result when it is empty or when its
    // current result leaves in this same cycle.
    assign s_ready = !valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    assign sig_bad     = (hdr_reg[0] != flv_pkg::SIG_F) || (hdr_reg[1] != flv_pkg::SIG_L)
                      || (hdr_reg[2] != flv_pkg::SIG_V);
    assign flag_bad    = ((hdr_reg[4] & flv_pkg::FLAG_RSV_HI) != 8'd0)
                      || ((hdr_reg[4] & flv_pkg::FLAG_RSV_LO) != 8'd0);
    assign data_offset = {hdr_reg[5], hdr_reg[6], hdr_reg[7], s_in_byte};
    assign off_bad     = (hdr_reg[3] == flv_pkg::VERSION_ONE)
                      && (data_offset != flv_pkg::DATA_OFFSET);

    assign tag_type    = hdr_reg[0][4:0];
    assign tag_rsv_bad = (hdr_reg[0] & flv_pkg::TAG_RSV_MASK) != 8'd0;
    assign type_bad    = (tag_type != flv_pkg::TYPE_SCRIPT) && (tag_type != flv_pkg::TYPE_VIDEO)
                      && (tag_type != flv_pkg::TYPE_AUDIO);
    assign sid_bad     = {s_in_byte, hdr_reg[9], hdr_reg[8]} != 24'd0;
    assign tag_size    = {hdr_reg[1], hdr_reg[2], hdr_reg[3]};

    always_comb begin
        phase_next   = phase_reg;
        idx_next     = idx_reg;
        left_next    = left_reg;
        err_next     = err_reg;
        version_next = version_reg;
        audio_next   = audio_reg;
        video_next   = video_reg;
        prior_next   = prior_reg;
        filter_next  = filter_reg;
        kind_next    = kind_reg;
        size_next    = size_reg;
        ts_next      = ts_reg;
        event_next   = flv_pkg::EV_CONSUMED;
        pbyte_next   = 8'd0;
        plast_next   = 1'b0;
        hdr_we       = 1'b0;

        case (phase_reg)
            flv_pkg::PH_FILE_HDR: begin
                hdr_we = idx_reg < 4'(flv_pkg::HDR_DEPTH);
                if (idx_reg >= flv_pkg::FILE_HDR_LAST) begin
                    idx_next = 4'd0;
                    // First fault in check order wins.
                    if (sig_bad) begin
                        err_next = flv_pkg::ERR_SIGNATURE;
                    end else if (flag_bad) begin
                        err_next = flv_pkg::ERR_FLAG_RSV;
                    end else if (off_bad) begin
                        err_next = flv_pkg::ERR_OFFSET;
                    end
                    if (sig_bad || flag_bad || off_bad) begin
                        phase_next = flv_pkg::PH_ERROR;
                        event_next = flv_pkg::EV_ERROR;
                    end else begin
                        version_next = hdr_reg[3];
                        audio_next   = hdr_reg[4][2];
                        video_next   = hdr_reg[4][0];
                        phase_next   = flv_pkg::PH_PREV_SIZE;
                        event_next   = flv_pkg::EV_FILE_OK;
                    end
                end else begin
                    idx_next = idx_reg + 4'd1;
                end
            end
            flv_pkg::PH_PREV_SIZE: begin
                hdr_we = idx_reg < 4'(flv_pkg::HDR_DEPTH);
                if (idx_reg >= flv_pkg::PREV_SIZE_LAST) begin
                    idx_next   = 4'd0;
                    prior_next = {hdr_reg[0], hdr_reg[1], hdr_reg[2], s_in_byte};
                    phase_next = flv_pkg::PH_TAG_HDR;
                    event_next = flv_pkg::EV_PREV_DONE;
                end else begin
                    idx_next = idx_reg + 4'd1;
                end
            end
            flv_pkg::PH_TAG_HDR: begin
                hdr_we = idx_reg < 4'(flv_pkg::HDR_DEPTH);
                if (idx_reg >= flv_pkg::TAG_HDR_LAST) begin
                    idx_next = 4'd0;
                    if (tag_rsv_bad) begin
                        err_next = flv_pkg::ERR_TAG_RSV;
                    end else if (type_bad) begin
                        err_next = flv_pkg::ERR_TYPE;
                    end else if (sid_bad) begin
                        err_next = flv_pkg::ERR_STREAM_ID;
                    end
                    if (tag_rsv_bad || type_bad || sid_bad) begin
                        phase_next = flv_pkg::PH_ERROR;
                        event_next = flv_pkg::EV_ERROR;
                    end else begin
                        // The timestamp's extended byte is its upper eight bits.
                        ts_next     = {hdr_reg[7], hdr_reg[4], hdr_reg[5], hdr_reg[6]};
                        size_next   = tag_size;
                        kind_next   = tag_type;
                        filter_next = hdr_reg[0][5];
                        left_next   = tag_size;
                        // An empty tag goes straight to the next size word.
                        phase_next  = (tag_size == 24'd0) ? flv_pkg::PH_PREV_SIZE
                                                          : flv_pkg::PH_PAYLOAD;
                        event_next  = flv_pkg::EV_TAG_OK;
                    end
                end else begin
                    idx_next = idx_reg + 4'd1;
                end
            end
            flv_pkg::PH_PAYLOAD: begin
                event_next = flv_pkg::EV_PAYLOAD;
                pbyte_next = s_in_byte;
                if (left_reg <= 24'd1) begin
                    left_next  = 24'd0;
                    plast_next = 1'b1;
                    idx_next   = 4'd0;
                    phase_next = flv_pkg::PH_PREV_SIZE;
                end else begin
                    left_next = left_reg - 24'd1;
                end
            end
            flv_pkg::PH_ERROR: begin
                event_next = flv_pkg::EV_ERROR;
            end
            default: begin
                err_next   = flv_pkg::ERR_STUCK;
                phase_next = flv_pkg::PH_ERROR;
                event_next = flv_pkg::EV_ERROR;
            end
        endcase

        code_next = (event_next == flv_pkg::EV_ERROR) ? err_next : flv_pkg::ERR_NONE;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= flv_pkg::PH_FILE_HDR;
            idx_reg     <= 4'd0;
            left_reg    <= 24'd0;
            err_reg     <= flv_pkg::ERR_NONE;
            version_reg <= 8'd0;
            audio_reg   <= 1'b0;
            video_reg   <= 1'b0;
            prior_reg   <= 32'd0;
            filter_reg  <= 1'b0;
            kind_reg    <= 5'd0;
            size_reg    <= 24'd0;
            ts_reg      <= 32'd0;
            valid_reg   <= 1'b0;
        end else begin
            if (accept) begin
                phase_reg   <= phase_next;
                idx_reg     <= idx_next;
                left_reg    <= left_next;
                err_reg     <= err_next;
                version_reg <= version_next;
                audio_reg   <= audio_next;
                video_reg   <= video_next;
                prior_reg   <= prior_next;
                filter_reg  <= filter_next;
                kind_reg    <= kind_next;
                size_reg    <= size_next;
                ts_reg      <= ts_next;
                valid_reg   <= 1'b1;
            end else if (m_ready) begin
                valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers: header byte store and the per-byte result fields.
    always_ff @(posedge aclk) begin
        if (accept) begin
            if (hdr_we) begin
                hdr_reg[idx_reg] <= s_in_byte;
            end
            event_reg <= event_next;
            code_reg  <= code_next;
            pbyte_reg <= pbyte_next;
            plast_reg <= plast_next;
        end
    end

    assign m_valid          = valid_reg;
    assign m_event_res      = event_reg;
    assign m_error_code     = code_reg;
    assign m_version        = version_reg;
    assign m_has_audio      = audio_reg;
    assign m_has_video      = video_reg;
    assign m_prior_tag_size = prior_reg;
    assign m_filter_flag    = filter_reg;
    assign m_tag_kind       = kind_reg;
    assign m_payload_size   = size_reg;
    assign m_time_stamp     = ts_reg;
    assign m_payload_byte   = pbyte_reg;
    assign m_payload_last   = plast_reg;

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// FLV tag stream parser testbench
// Streams a generated FLV byte sequence through the parser with bursty input
// and a stalling result side, predicts every result transaction in a
// scoreboard, and compares each result field by field.
// ----------------------------------------------------------------------------

typedef struct {
    logic [2:0]  event_res;
    logic [2:0]  error_code;
    logic [7:0]  version;
    logic        has_audio;
    logic        has_video;
    logic [31:0] prior_tag_size;
    logic        filter_flag;
    logic [4:0]  tag_kind;
    logic [23:0] payload_size;
    logic [31:0] time_stamp;
    logic [7:0]  payload_byte;
    logic        payload_last;
} parse_result_t;

class flv_parse_scoreboard;
    // Parser state as the scoreboard tracks it.
    logic [2:0]  phase;
    logic [3:0]  idx;
    logic [7:0]  hdr [flv_pkg::HDR_DEPTH];
    logic [23:0] bytes_left;
    logic [7:0]  version;
    logic        has_audio;
    logic        has_video;
    logic [31:0] prior_tag_size;
    logic        filter_flag;
    logic [4:0]  tag_kind;
    logic [23:0] payload_size;
    logic [31:0] time_stamp;
    logic [2:0]  err_code;

    parse_result_t pending_events[$];
    int mismatches;

    function new();
        phase          = flv_pkg::PH_FILE_HDR;
        idx            = '0;
        foreach (hdr[i]) hdr[i] = 8'h00;
        bytes_left     = '0;
        version        = '0;
        has_audio      = 1'b0;
        has_video      = 1'b0;
        prior_tag_size = '0;
        filter_flag    = 1'b0;
        tag_kind       = '0;
        payload_size   = '0;
        time_stamp     = '0;
        err_code       = flv_pkg::ERR_NONE;
        mismatches     = 0;
    endfunction

    function logic [2:0] enter_error(logic [2:0] code);
        err_code = code;
        phase    = flv_pkg::PH_ERROR;
        return flv_pkg::EV_ERROR;
    endfunction

    // Advances the tracked state by one accepted byte and queues its result.
    function void note_byte(logic [7:0] b);
        parse_result_t r;
        logic [2:0]  ev;
        logic [2:0]  code;
        logic [31:0] offset;
        logic [4:0]  kind;
        ev = flv_pkg::EV_CONSUMED;
        code = flv_pkg::ERR_NONE;
        r.payload_byte = 8'h00;
        r.payload_last = 1'b0;
        case (phase)
            flv_pkg::PH_FILE_HDR: begin
                hdr[idx] = b;
                if (idx >= flv_pkg::FILE_HDR_LAST) begin
                    idx = '0;
                    offset = {hdr[5], hdr[6], hdr[7], hdr[8]};
                    if (hdr[0] != flv_pkg::SIG_F || hdr[1] != flv_pkg::SIG_L
                        || hdr[2] != flv_pkg::SIG_V)
                        code = flv_pkg::ERR_SIGNATURE;
                    else if ((hdr[4] & (flv_pkg::FLAG_RSV_HI | flv_pkg::FLAG_RSV_LO)) != 8'h00)
                        code = flv_pkg::ERR_FLAG_RSV;
                    else if (hdr[3] == flv_pkg::VERSION_ONE && offset != flv_pkg::DATA_OFFSET)
                        code = flv_pkg::ERR_OFFSET;
                    if (code != flv_pkg::ERR_NONE) begin
                        ev = enter_error(code);
                    end else begin
                        version   = hdr[3];
                        has_audio = hdr[4][2];
                        has_video = hdr[4][0];
                        phase     = flv_pkg::PH_PREV_SIZE;
                        ev        = flv_pkg::EV_FILE_OK;
                    end
                end else begin
                    idx = idx + 4'd1;
                end
            end
            flv_pkg::PH_PREV_SIZE: begin
                hdr[idx] = b;
                if (idx >= flv_pkg::PREV_SIZE_LAST) begin
                    idx = '0;
                    prior_tag_size = {hdr[0], hdr[1], hdr[2], hdr[3]};
                    phase = flv_pkg::PH_TAG_HDR;
                    ev = flv_pkg::EV_PREV_DONE;
                end else begin
                    idx = idx + 4'd1;
                end
            end
            flv_pkg::PH_TAG_HDR: begin
                hdr[idx] = b;
                if (idx >= flv_pkg::TAG_HDR_LAST) begin
                    idx = '0;
                    kind = hdr[0][4:0];
                    if ((hdr[0] & flv_pkg::TAG_RSV_MASK) != 8'h00)
                        code = flv_pkg::ERR_TAG_RSV;
                    else if (!(kind inside {flv_pkg::TYPE_AUDIO, flv_pkg::TYPE_VIDEO,
                                            flv_pkg::TYPE_SCRIPT}))
                        code = flv_pkg::ERR_TYPE;
                    else if ({hdr[10], hdr[9], hdr[8]} != 24'h0)
                        code = flv_pkg::ERR_STREAM_ID;
                    if (code != flv_pkg::ERR_NONE) begin
                        ev = enter_error(code);
                    end else begin
                        time_stamp   = {hdr[7], hdr[4], hdr[5], hdr[6]};
                        payload_size = {hdr[1], hdr[2], hdr[3]};
                        tag_kind     = kind;
                        filter_flag  = hdr[0][5];
                        bytes_left   = payload_size;
                        phase = (payload_size == 24'h0) ? flv_pkg::PH_PREV_SIZE
                                                        : flv_pkg::PH_PAYLOAD;
                        ev = flv_pkg::EV_TAG_OK;
                    end
                end else begin
                    idx = idx + 4'd1;
                end
            end
            flv_pkg::PH_PAYLOAD: begin
                ev = flv_pkg::EV_PAYLOAD;
                r.payload_byte = b;
                if (bytes_left <= 24'd1) begin
                    bytes_left = '0;
                    r.payload_last = 1'b1;
                    idx = '0;
                    phase = flv_pkg::PH_PREV_SIZE;
                end else begin
                    bytes_left = bytes_left - 24'd1;
                end
            end
            flv_pkg::PH_ERROR: begin
                ev = flv_pkg::EV_ERROR;
            end
            default: begin
                ev = enter_error(flv_pkg::ERR_STUCK);
            end
        endcase
        r.event_res      = ev;
        r.error_code     = (ev == flv_pkg::EV_ERROR) ? err_code : flv_pkg::ERR_NONE;
        r.version        = version;
        r.has_audio      = has_audio;
        r.has_video      = has_video;
        r.prior_tag_size = prior_tag_size;
        r.filter_flag    = filter_flag;
        r.tag_kind       = tag_kind;
        r.payload_size   = payload_size;
        r.time_stamp     = time_stamp;
        pending_events.push_back(r);
    endfunction

    function void compare_field(string name, logic [31:0] e, logic [31:0] a);
        if (a !== e) begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, e, a);
        end
    endfunction

    function void check_result(parse_result_t act);
        parse_result_t exp;
        if (pending_events.size() == 0) begin
            mismatches++;
            $display("%0t: unexpected result, expected none, actual event %0d",
                     $time, act.event_res);
            return;
        end
        exp = pending_events.pop_front();
        compare_field("event_res",      32'(exp.event_res),      32'(act.event_res));
        compare_field("error_code",     32'(exp.error_code),     32'(act.error_code));
        compare_field("version",        32'(exp.version),        32'(act.version));
        compare_field("has_audio",      32'(exp.has_audio),      32'(act.has_audio));
        compare_field("has_video",      32'(exp.has_video),      32'(act.has_video));
        compare_field("prior_tag_size", exp.prior_tag_size,      act.prior_tag_size);
        compare_field("filter_flag",    32'(exp.filter_flag),    32'(act.filter_flag));
        compare_field("tag_kind",       32'(exp.tag_kind),       32'(act.tag_kind));
        compare_field("payload_size",   32'(exp.payload_size),   32'(act.payload_size));
        compare_field("time_stamp",     exp.time_stamp,          act.time_stamp);
        compare_field("payload_byte",   32'(exp.payload_byte),   32'(act.payload_byte));
        compare_field("payload_last",   32'(exp.payload_last),   32'(act.payload_last));
    endfunction

    function int pending();
        return pending_events.size();
    endfunction
endclass

module testbench;

    // The run ends in failure after this many cycles in which neither channel
    // moves a transaction. The longest legal quiet stretch is the receiver
    // hold-off plus one sender gap, far below this.
    localparam int IDLE_LIMIT   = 2000;
    localparam int HOLD_CYCLES  = 150;
    localparam int STREAM_ITEMS = 1750;
    localparam int DRAIN_CYCLES = 10;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [7:0]  s_in_byte = 8'h00;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [2:0]  m_event_res;
    logic [2:0]  m_error_code;
    logic [7:0]  m_version;
    logic        m_has_audio;
    logic        m_has_video;
    logic [31:0] m_prior_tag_size;
    logic        m_filter_flag;
    logic [4:0]  m_tag_kind;
    logic [23:0] m_payload_size;
    logic [31:0] m_time_stamp;
    logic [7:0]  m_payload_byte;
    logic        m_payload_last;

    flv_parse_scoreboard sb = new();

    // The whole byte stream is generated up front and then played out.
    logic [7:0] byte_stream[$];
    int         idle_cycles = 0;

    flv_tag_stream_parser i_dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_in_byte        (s_in_byte),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_event_res      (m_event_res),
        .m_error_code     (m_error_code),
        .m_version        (m_version),
        .m_has_audio      (m_has_audio),
        .m_has_video      (m_has_video),
        .m_prior_tag_size (m_prior_tag_size),
        .m_filter_flag    (m_filter_flag),
        .m_tag_kind       (m_tag_kind),
        .m_payload_size   (m_payload_size),
        .m_time_stamp     (m_time_stamp),
        .m_payload_byte   (m_payload_byte),
        .m_payload_last   (m_payload_last)
    );

    always #6 aclk = ~aclk;

    // ------------------------------------------------------------------------
    // Stream construction. Multi-byte fields follow the FLV layout: sizes and
    // offsets are big-endian, the timestamp puts its extension byte last and
    // the stream id is stored low byte first as the parser assembles it.
    // ------------------------------------------------------------------------
    task automatic add_word(logic [31:0] w);
        byte_stream.push_back(w[31:24]);
        byte_stream.push_back(w[23:16]);
        byte_stream.push_back(w[15:8]);
        byte_stream.push_back(w[7:0]);
    endtask

    task automatic add_file_header(logic [23:0] sig, logic [7:0] ver, logic [7:0] flags,
                                   logic [31:0] offset);
        byte_stream.push_back(sig[23:16]);
        byte_stream.push_back(sig[15:8]);
        byte_stream.push_back(sig[7:0]);
        byte_stream.push_back(ver);
        byte_stream.push_back(flags);
        add_word(offset);
    endtask

    task automatic add_tag_header(logic [7:0] b0, logic [23:0] size, logic [31:0] ts,
                                  logic [23:0] sid);
        byte_stream.push_back(b0);
        byte_stream.push_back(size[23:16]);
        byte_stream.push_back(size[15:8]);
        byte_stream.push_back(size[7:0]);
        byte_stream.push_back(ts[23:16]);
        byte_stream.push_back(ts[15:8]);
        byte_stream.push_back(ts[7:0]);
        byte_stream.push_back(ts[31:24]);
        byte_stream.push_back(sid[7:0]);
        byte_stream.push_back(sid[15:8]);
        byte_stream.push_back(sid[23:16]);
    endtask

    task automatic add_payload(int n);
        repeat (n) byte_stream.push_back(8'($urandom_range(0, 255)));
    endtask

    // First byte of a tag header that passes its checks.
    function automatic logic [7:0] good_tag_byte0();
        logic [4:0] kind;
        logic       filt;
        filt = 1'($urandom_range(0, 1));
        case ($urandom_range(0, 2))
            0:       kind = flv_pkg::TYPE_AUDIO;
            1:       kind = flv_pkg::TYPE_VIDEO;
            default: kind = flv_pkg::TYPE_SCRIPT;
        endcase
        return {2'b00, filt, kind};
    endfunction

    // Mostly short payloads so that many tag headers pass through the parser.
    function automatic logic [23:0] random_size();
        int r;
        r = $urandom_range(0, 99);
        if (r < 15)      return 24'd0;
        else if (r < 80) return 24'($urandom_range(1, 16));
        else if (r < 97) return 24'($urandom_range(17, 80));
        else             return 24'($urandom_range(81, 400));
    endfunction

    task automatic build_stream();
        logic [23:0] sig;
        logic [7:0]  ver;
        logic [7:0]  flags;
        logic [7:0]  rsv;
        logic [7:0]  b0;
        logic [31:0] offset;
        logic [23:0] size;
        logic [23:0] sid;
        logic [4:0]  kind;
        logic        aud;
        logic        vid;
        sig = {flv_pkg::SIG_F, flv_pkg::SIG_L, flv_pkg::SIG_V};
        aud = 1'($urandom_range(0, 1));
        vid = 1'($urandom_range(0, 1));
        flags = {5'b00000, aud, 1'b0, vid};
        // A version other than one skips the data offset check, so the offset
        // is then any value at all.
        if ($urandom_range(0, 1)) begin
            ver = flv_pkg::VERSION_ONE;
            offset = flv_pkg::DATA_OFFSET;
        end else begin
            ver = ($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom_range(2, 255));
            offset = $urandom();
        end

        // Reset can be applied only once, so a run either breaks its file header
        // (rarely) or parses a long stream and ends it in a bad or unfinished tag.
        if ($urandom_range(0, 7) == 0) begin
            case ($urandom_range(1, 3))
                1: begin
                    sig[8 * $urandom_range(0, 2) +: 8] ^= 8'($urandom_range(1, 255));
                    if ($urandom_range(0, 1))
                        flags |= flv_pkg::FLAG_RSV_LO;
                end
                2: begin
                    rsv = 8'($urandom_range(1, 255))
                        & (flv_pkg::FLAG_RSV_HI | flv_pkg::FLAG_RSV_LO);
                    flags |= (rsv == 8'h00) ? flv_pkg::FLAG_RSV_HI : rsv;
                    if ($urandom_range(0, 1)) begin
                        ver = flv_pkg::VERSION_ONE;
                        offset = flv_pkg::DATA_OFFSET ^ (32'h1 << $urandom_range(0, 31));
                    end
                end
                default: begin
                    // Any bit of the full 32-bit offset differing counts,
                    // including the upper bytes.
                    ver = flv_pkg::VERSION_ONE;
                    offset = flv_pkg::DATA_OFFSET ^ (32'h1 << $urandom_range(0, 31));
                end
            endcase
            add_file_header(sig, ver, flags, offset);
            add_payload(STREAM_ITEMS - 9);
            return;
        end

        add_file_header(sig, ver, flags, offset);
        // Directed record: zero previous size, a filtered script tag with the
        // largest timestamp and no payload.
        add_word(32'h0000_0000);
        add_tag_header({2'b00, 1'b1, flv_pkg::TYPE_SCRIPT}, 24'd0, 32'hffff_ffff, 24'h0);

        size = 24'd0;
        while (byte_stream.size() < STREAM_ITEMS - 60) begin
            if ($urandom_range(0, 1))
                add_word($urandom());
            else
                add_word(32'd11 + size);
            size = random_size();
            add_tag_header(good_tag_byte0(), size, $urandom(), 24'h0);
            add_payload(int'(size));
        end

        add_word($urandom());
        case ($urandom_range(0, 3))
            0: begin
                // Reserved bits set; the type and stream id may be wrong too.
                rsv = 8'($urandom_range(1, 3)) << 6;
                b0 = rsv | 8'($urandom_range(0, 63));
                sid = $urandom_range(0, 1) ? 24'($urandom()) : 24'h0;
                add_tag_header(b0, random_size(), $urandom(), sid);
                add_payload(30);
            end
            1: begin
                do kind = 5'($urandom_range(0, 31));
                while (kind inside {flv_pkg::TYPE_AUDIO, flv_pkg::TYPE_VIDEO,
                                    flv_pkg::TYPE_SCRIPT});
                b0 = {2'b00, 1'($urandom_range(0, 1)), kind};
                sid = $urandom_range(0, 1) ? 24'($urandom()) : 24'h0;
                add_tag_header(b0, random_size(), $urandom(), sid);
                add_payload(30);
            end
            2: begin
                sid = (24'h1 << $urandom_range(0, 23)) | 24'($urandom_range(0, 1) ? $urandom() : 0);
                add_tag_header(good_tag_byte0(), random_size(), $urandom(), sid);
                add_payload(30);
            end
            default: begin
                // A huge tag that the stream simply stops inside of.
                size = $urandom_range(0, 1) ? 24'hff_ffff : (24'h80_0000 | 24'($urandom()));
                add_tag_header(good_tag_byte0(), size, $urandom(), 24'h0);
                add_payload(40);
            end
        endcase
    endtask

    // ------------------------------------------------------------------------
    // Sender: plays the stream out in bursts of random length with random
    // gaps. Valid stays high across back-to-back bytes and is only lowered
    // when a gap follows an accepted transaction.
    // ------------------------------------------------------------------------
    task automatic send_stream();
        int burst;
        int gap;
        burst = 0;
        foreach (byte_stream[k]) begin
            if (burst == 0) begin
                burst = $urandom_range(1, 64);
                gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
                if (gap > 0) begin
                    s_valid <= 1'b0;
                    repeat (gap) @(posedge aclk);
                end
            end
            s_valid   <= 1'b1;
            s_in_byte <= byte_stream[k];
            do @(posedge aclk); while (!s_ready);
            burst--;
        end
        s_valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Receiver: switches between stall patterns in segments. Once, early in
    // the run, it holds ready low for a long stretch so that the parser's
    // output fills and back-pressure reaches the input channel.
    // ------------------------------------------------------------------------
    initial begin : result_sink
        int hold_at;
        int cyc;
        int seg;
        int mode;
        hold_at = $urandom_range(40, 120);
        cyc = 0;
        @(posedge aclk iff aresetn);
        forever begin
            mode = $urandom_range(0, 3);
            seg = $urandom_range(16, 160);
            for (int k = 0; k < seg; k++) begin
                if (cyc == hold_at) begin
                    m_ready <= 1'b0;
                    repeat (HOLD_CYCLES) @(posedge aclk);
                end
                case (mode)
                    0:       m_ready <= 1'b1;
                    1:       m_ready <= ($urandom_range(0, 3) != 0);
                    2:       m_ready <= ((k % 5) < 3);
                    default: m_ready <= 1'($urandom_range(0, 1));
                endcase
                cyc++;
                @(posedge aclk);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: a single process records accepted input bytes before it looks
    // at results, so the prediction for a byte always exists by the time its
    // result can be seen. It also runs the watchdog on quiet cycles.
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        parse_result_t act;
        if (aresetn) begin
            if (s_valid && s_ready)
                sb.note_byte(s_in_byte);
            if (m_valid && m_ready) begin
                act.event_res      = m_event_res;
                act.error_code     = m_error_code;
                act.version        = m_version;
                act.has_audio      = m_has_audio;
                act.has_video      = m_has_video;
                act.prior_tag_size = m_prior_tag_size;
                act.filter_flag    = m_filter_flag;
                act.tag_kind       = m_tag_kind;
                act.payload_size   = m_payload_size;
                act.time_stamp     = m_time_stamp;
                act.payload_byte   = m_payload_byte;
                act.payload_last   = m_payload_last;
                sb.check_result(act);
            end
            if ((s_valid && s_ready) || (m_valid && m_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("%0t: no transaction for %0d cycles", $time, IDLE_LIMIT);
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence: build the stream, reset once, send everything, wait for
    // the last result plus DRAIN_CYCLES to catch stray transactions, report.
    // ------------------------------------------------------------------------
    initial begin
        build_stream();
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        send_stream();
        while (sb.pending() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
